FILE: src/tgd_pkg.sv
// Shared types and constants for the touch gesture detector.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package tgd_pkg;

	localparam int unsigned COORD_W = 12;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned HOLD_W  = 16;
	localparam int unsigned CFG_W   = 16;
	localparam int unsigned IDX_W   = 3;

	// Event codes reported on event_kind.
	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_TAP     = 3'd1,
		EV_LONG    = 3'd2,
		EV_CORNER  = 3'd3,
		EV_RELEASE = 3'd4
	} event_kind_t;

	// Configuration register indexes.
	typedef enum logic [IDX_W-1:0] {
		REG_MOVE_CANCEL   = 3'd0,
		REG_LONG_PRESS    = 3'd1,
		REG_CORNER_LEFT   = 3'd2,
		REG_CORNER_RIGHT  = 3'd3,
		REG_CORNER_TOP    = 3'd4,
		REG_CORNER_BOTTOM = 3'd5,
		REG_CORNER_HOLD   = 3'd6,
		REG_TAP_DEBOUNCE  = 3'd7
	} reg_index_t;

	// Reset values of the configuration registers.
	localparam logic [COORD_W-1:0] MOVE_CANCEL_RST  = 12'd20;
	localparam logic [HOLD_W-1:0]  LONG_PRESS_RST   = 16'd800;
	localparam logic [HOLD_W-1:0]  CORNER_HOLD_RST  = 16'd2000;
	localparam logic [HOLD_W-1:0]  TAP_DEBOUNCE_RST = 16'd100;

	typedef struct packed {
		logic [COORD_W-1:0] move_cancel_px;
		logic [HOLD_W-1:0]  long_press_ms;
		logic [COORD_W-1:0] corner_left;
		logic [COORD_W-1:0] corner_right;
		logic [COORD_W-1:0] corner_top;
		logic [COORD_W-1:0] corner_bottom;
		logic [HOLD_W-1:0]  corner_hold_ms;
		logic [HOLD_W-1:0]  tap_debounce_ms;
	} cfg_t;

	// One touch-panel sample.
	typedef struct packed {
		logic               touched;
		logic [COORD_W-1:0] pos_x;
		logic [COORD_W-1:0] pos_y;
		logic [TIME_W-1:0]  now_ms;
	} sample_t;

	// Gesture tracking state carried from sample to sample.
	typedef struct packed {
		logic               was_pressed;
		logic [COORD_W-1:0] last_x;
		logic [COORD_W-1:0] last_y;
		logic [TIME_W-1:0]  anchor_time;
		logic [COORD_W-1:0] anchor_x;
		logic [COORD_W-1:0] anchor_y;
		logic [TIME_W-1:0]  last_tap_time;
		logic               long_done;
		logic [TIME_W-1:0]  zone_start_time;
		logic               zone_tracking;
		logic               zone_done;
	} gest_state_t;

	// One result item.
	typedef struct packed {
		event_kind_t        kind;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               pressed_now;
	} result_t;

	function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
			input logic [COORD_W-1:0] b);
		abs_diff = (a >= b) ? (a - b) : (b - a);
	endfunction

endpackage

FILE: src/tgd_cfg.sv
// Configuration register file of the touch gesture detector.
// Depends on tgd_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module tgd_cfg
	import tgd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	output cfg_t                cfg
);

	cfg_t cfg_q;

	// Decode the write index; each register keeps its own width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.move_cancel_px  <= MOVE_CANCEL_RST;
			cfg_q.long_press_ms   <= LONG_PRESS_RST;
			cfg_q.corner_left     <= '0;
			cfg_q.corner_right    <= '0;
			cfg_q.corner_top      <= '0;
			cfg_q.corner_bottom   <= '0;
			cfg_q.corner_hold_ms  <= CORNER_HOLD_RST;
			cfg_q.tap_debounce_ms <= TAP_DEBOUNCE_RST;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_MOVE_CANCEL:   cfg_q.move_cancel_px  <= cfg_data[COORD_W-1:0];
				REG_LONG_PRESS:    cfg_q.long_press_ms   <= cfg_data[HOLD_W-1:0];
				REG_CORNER_LEFT:   cfg_q.corner_left     <= cfg_data[COORD_W-1:0];
				REG_CORNER_RIGHT:  cfg_q.corner_right    <= cfg_data[COORD_W-1:0];
				REG_CORNER_TOP:    cfg_q.corner_top      <= cfg_data[COORD_W-1:0];
				REG_CORNER_BOTTOM: cfg_q.corner_bottom   <= cfg_data[COORD_W-1:0];
				REG_CORNER_HOLD:   cfg_q.corner_hold_ms  <= cfg_data[HOLD_W-1:0];
				REG_TAP_DEBOUNCE:  cfg_q.tap_debounce_ms <= cfg_data[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: src/tgd_core.sv
// Combinational gesture step: next tracking state and the result of one sample.
// Depends on tgd_pkg for the state, sample, config and result types.
`timescale 1ns / 1ps

module tgd_core
	import tgd_pkg::*;
(
	input  cfg_t        cfg,
	input  sample_t     smp,
	input  gest_state_t cur,
	output gest_state_t nxt,
	output result_t     res
);

	logic               prev;
	logic               new_press;
	logic [COORD_W-1:0] lx;
	logic [COORD_W-1:0] ly;
	logic               drift;
	logic [TIME_W-1:0]  hold_time;
	logic [TIME_W-1:0]  zone_time;
	logic [TIME_W-1:0]  tap_gap;
	logic               in_zone;
	logic               zone_trk_eff;
	logic               zone_done_eff;
	event_kind_t        kind;

	// Elapsed times use wrapping subtraction.
	assign hold_time = smp.now_ms - cur.anchor_time;
	assign zone_time = smp.now_ms - cur.zone_start_time;
	assign tap_gap   = smp.now_ms - cur.last_tap_time;

	assign prev      = cur.was_pressed;
	assign new_press = smp.touched && !prev;
	assign lx        = smp.touched ? smp.pos_x : cur.last_x;
	assign ly        = smp.touched ? smp.pos_y : cur.last_y;

	// Drift is only looked at while a press continues, so the old anchor applies.
	assign drift = (abs_diff(lx, cur.anchor_x) > cfg.move_cancel_px) ||
		(abs_diff(ly, cur.anchor_y) > cfg.move_cancel_px);

	assign in_zone = smp.touched &&
		(lx >= cfg.corner_left) && (lx <= cfg.corner_right) &&
		(ly >= cfg.corner_top) && (ly <= cfg.corner_bottom);

	// A new press clears the zone flags before the zone check sees them.
	assign zone_trk_eff  = new_press ? 1'b0 : cur.zone_tracking;
	assign zone_done_eff = new_press ? 1'b0 : cur.zone_done;

	always_comb begin
		nxt             = cur;
		kind            = EV_NONE;
		nxt.was_pressed = smp.touched;
		nxt.last_x      = lx;
		nxt.last_y      = ly;

		// Press edge: anchor point and time.
		if (new_press) begin
			nxt.anchor_time = smp.now_ms;
			nxt.anchor_x    = smp.pos_x;
			nxt.anchor_y    = smp.pos_y;
			nxt.long_done   = 1'b0;
		end

		// Held press: re-anchor on drift, otherwise check the hold time.
		if (smp.touched && prev && !cur.long_done) begin
			if (drift) begin
				nxt.anchor_time = smp.now_ms;
				nxt.anchor_x    = lx;
				nxt.anchor_y    = ly;
			end else if (hold_time >= {{(TIME_W-HOLD_W){1'b0}}, cfg.long_press_ms}) begin
				kind          = EV_LONG;
				nxt.long_done = 1'b1;
			end
		end

		// Corner zone timer; a long press from this sample takes precedence.
		nxt.zone_done = zone_done_eff;
		if (in_zone) begin
			if (!zone_trk_eff) begin
				nxt.zone_tracking   = 1'b1;
				nxt.zone_start_time = smp.now_ms;
			end else begin
				nxt.zone_tracking = 1'b1;
				if (!zone_done_eff &&
						(zone_time >= {{(TIME_W-HOLD_W){1'b0}}, cfg.corner_hold_ms})) begin
					if (kind == EV_NONE) begin
						kind = EV_CORNER;
					end
					nxt.zone_done = 1'b1;
				end
			end
		end else begin
			nxt.zone_tracking = 1'b0;
		end

		// Release edge: debounced tap unless a long or corner press happened, else a release event.
		if (!smp.touched && prev) begin
			if (!cur.long_done && !cur.zone_done &&
					(tap_gap >= {{(TIME_W-HOLD_W){1'b0}}, cfg.tap_debounce_ms})) begin
				kind              = EV_TAP;
				nxt.last_tap_time = smp.now_ms;
			end
			if (kind == EV_NONE) begin
				kind = EV_RELEASE;
			end
		end

		res.kind        = kind;
		res.x           = (kind != EV_NONE) ? lx : '0;
		res.y           = (kind != EV_NONE) ? ly : '0;
		res.pressed_now = smp.touched;
	end

endmodule

FILE: src/touch_gesture_detector.sv
// Touch gesture detector: tap, long press, corner long press and release events.
// Input and result registers; the state update sits between the two registers.
// Throughput: one sample per cycle unless out_stall holds a full result register.
// Reset: asynchronous, active low; clears both stages, the gesture state and
// loads the configuration reset values. Instantiates tgd_cfg and tgd_core.
`timescale 1ns / 1ps

module touch_gesture_detector
	import tgd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// Configuration write port
	input  logic               cfg_we,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	// Sample input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               touched,
	input  logic [COORD_W-1:0] pos_x,
	input  logic [COORD_W-1:0] pos_y,
	input  logic [TIME_W-1:0]  now_ms,
	// Event output channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         event_kind,
	output logic [COORD_W-1:0] event_x,
	output logic [COORD_W-1:0] event_y,
	output logic               pressed_now
);

	cfg_t        cfg;
	sample_t     smp_s1;
	logic        valid_s1;
	logic        valid_s2;
	result_t     res_s2;
	result_t     res_d;
	gest_state_t state_q;
	gest_state_t state_d;
	logic        adv_s1;

	tgd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tgd_core u_core (
		.cfg (cfg),
		.smp (smp_s1),
		.cur (state_q),
		.nxt (state_d),
		.res (res_d)
	);

	// Stage 1 moves into the result register when that register is free or drains.
	assign adv_s1   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			smp_s1.touched <= touched;
			smp_s1.pos_x   <= pos_x;
			smp_s1.pos_y   <= pos_y;
			smp_s1.now_ms  <= now_ms;
		end
	end

	// Gesture state advances once per sample, when it leaves stage 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			state_q <= state_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_d;
		end
	end

	assign out_valid   = valid_s2;
	assign event_kind  = res_s2.kind;
	assign event_x     = res_s2.x;
	assign event_y     = res_s2.y;
	assign pressed_now = res_s2.pressed_now;

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for touch_gesture_detector: tap, long press, corner press, release.
// Depends on tgd_pkg for types and register codes, and on the block's top-level RTL.
`timescale 1ns / 1ps

module testbench;
	import tgd_pkg::*;

	localparam int QUIET_LIMIT  = 4000;
	localparam int PHASE_ITEMS  = 270;
	localparam int PHASE_COUNT  = 6;

	// Table of directed samples, with an optional hand-written expectation.
	typedef struct {
		logic               touched;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [TIME_W-1:0]  ms;
		bit                 typed;
		event_kind_t        kind;
		logic [COORD_W-1:0] ex;
		logic [COORD_W-1:0] ey;
	} stim_row_t;

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               cfg_we    = 1'b0;
	logic [IDX_W-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]   cfg_data  = '0;
	logic               in_valid  = 1'b0;
	logic               in_stall;
	logic               touched   = 1'b0;
	logic [COORD_W-1:0] pos_x     = '0;
	logic [COORD_W-1:0] pos_y     = '0;
	logic [TIME_W-1:0]  now_ms    = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [2:0]         event_kind;
	logic [COORD_W-1:0] event_x;
	logic [COORD_W-1:0] event_y;
	logic               pressed_now;

	// Predictor copy of the gesture state and the configuration registers.
	gest_state_t        gs;
	cfg_t               cfg;
	result_t            pending_events [$];
	stim_row_t          script [$];
	logic [CFG_W-1:0]   reg_words [8];
	logic [TIME_W-1:0]  clock_ms;
	int                 send_idle_pct;
	int                 stall_pct;
	int                 items_sent;
	int                 mismatches;
	int                 quiet_cycles;

	touch_gesture_detector dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.touched     (touched),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.now_ms      (now_ms),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.event_kind  (event_kind),
		.event_x     (event_x),
		.event_y     (event_y),
		.pressed_now (pressed_now)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic flag_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// Gesture prediction for one sample; updates the predictor state.
	function automatic result_t gesture_step(input sample_t s);
		logic               prev;
		logic               in_zone;
		logic [COORD_W-1:0] dx;
		logic [COORD_W-1:0] dy;
		event_kind_t        kind;
		result_t            r;
		prev = gs.was_pressed;
		kind = EV_NONE;
		gs.was_pressed = s.touched;
		if (s.touched) begin
			gs.last_x = s.pos_x;
			gs.last_y = s.pos_y;
		end
		// A new contact anchors the press and clears the per-contact flags.
		if (s.touched && !prev) begin
			gs.anchor_time   = s.now_ms;
			gs.anchor_x      = s.pos_x;
			gs.anchor_y      = s.pos_y;
			gs.long_done     = 1'b0;
			gs.zone_tracking = 1'b0;
			gs.zone_done     = 1'b0;
		end
		// Held contact: drift re-anchors, otherwise the hold timer may fire.
		if (s.touched && prev && !gs.long_done) begin
			dx = (gs.last_x > gs.anchor_x) ? gs.last_x - gs.anchor_x : gs.anchor_x - gs.last_x;
			dy = (gs.last_y > gs.anchor_y) ? gs.last_y - gs.anchor_y : gs.anchor_y - gs.last_y;
			if (dx > cfg.move_cancel_px || dy > cfg.move_cancel_px) begin
				gs.anchor_time = s.now_ms;
				gs.anchor_x    = gs.last_x;
				gs.anchor_y    = gs.last_y;
			end else if (TIME_W'(s.now_ms - gs.anchor_time) >= TIME_W'(cfg.long_press_ms)) begin
				kind = EV_LONG;
				gs.long_done = 1'b1;
			end
		end
		// Corner timer; a long press from the same sample keeps priority.
		in_zone = s.touched && gs.last_x >= cfg.corner_left && gs.last_x <= cfg.corner_right
			&& gs.last_y >= cfg.corner_top && gs.last_y <= cfg.corner_bottom;
		if (in_zone) begin
			if (!gs.zone_tracking) begin
				gs.zone_tracking   = 1'b1;
				gs.zone_start_time = s.now_ms;
			end else if (!gs.zone_done &&
					TIME_W'(s.now_ms - gs.zone_start_time) >= TIME_W'(cfg.corner_hold_ms)) begin
				if (kind == EV_NONE)
					kind = EV_CORNER;
				gs.zone_done = 1'b1;
			end
		end else begin
			gs.zone_tracking = 1'b0;
		end
		// Release: debounced tap unless a press event already fired.
		if (!s.touched && prev) begin
			if (!gs.long_done && !gs.zone_done &&
					TIME_W'(s.now_ms - gs.last_tap_time) >= TIME_W'(cfg.tap_debounce_ms)) begin
				kind = EV_TAP;
				gs.last_tap_time = s.now_ms;
			end
			if (kind == EV_NONE)
				kind = EV_RELEASE;
		end
		r.kind        = kind;
		r.x           = (kind != EV_NONE) ? gs.last_x : '0;
		r.y           = (kind != EV_NONE) ? gs.last_y : '0;
		r.pressed_now = s.touched;
		return r;
	endfunction

	// Present one sample and hold it until the transfer happens.
	task automatic send_sample(input sample_t s, input bit typed, input result_t want);
		result_t predicted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		touched  <= s.touched;
		pos_x    <= s.pos_x;
		pos_y    <= s.pos_y;
		now_ms   <= s.now_ms;
		do
			@(posedge clk);
		while (in_stall);
		predicted = gesture_step(s);
		pending_events.push_back(typed ? want : predicted);
		items_sent++;
	endtask

	// Stop sending and wait for every outstanding event.
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_events.size() != 0);
	endtask

	// Write all eight registers back to back from reg_words.
	task automatic load_config();
		reg_index_t idx;
		repeat (2) @(posedge clk);
		for (int i = 0; i < 8; i++) begin
			idx = reg_index_t'(i);
			cfg_we    <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= reg_words[i];
			@(posedge clk);
			case (idx)
				REG_MOVE_CANCEL:   cfg.move_cancel_px  = reg_words[i][COORD_W-1:0];
				REG_LONG_PRESS:    cfg.long_press_ms   = reg_words[i][HOLD_W-1:0];
				REG_CORNER_LEFT:   cfg.corner_left     = reg_words[i][COORD_W-1:0];
				REG_CORNER_RIGHT:  cfg.corner_right    = reg_words[i][COORD_W-1:0];
				REG_CORNER_TOP:    cfg.corner_top      = reg_words[i][COORD_W-1:0];
				REG_CORNER_BOTTOM: cfg.corner_bottom   = reg_words[i][COORD_W-1:0];
				REG_CORNER_HOLD:   cfg.corner_hold_ms  = reg_words[i][HOLD_W-1:0];
				REG_TAP_DEBOUNCE:  cfg.tap_debounce_ms = reg_words[i][HOLD_W-1:0];
			endcase
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Choose register values: 0 reset-like, 1 all zero, 2 all ones, 3 random, 4 empty zone.
	task automatic pick_config(input int mode);
		int lo;
		int hi;
		case (mode)
			0: begin
				reg_words[REG_MOVE_CANCEL]   = 20;
				reg_words[REG_LONG_PRESS]    = 800;
				reg_words[REG_CORNER_LEFT]   = 0;
				reg_words[REG_CORNER_RIGHT]  = 1023;
				reg_words[REG_CORNER_TOP]    = 0;
				reg_words[REG_CORNER_BOTTOM] = 1023;
				reg_words[REG_CORNER_HOLD]   = 2000;
				reg_words[REG_TAP_DEBOUNCE]  = 100;
			end
			1: begin
				for (int i = 0; i < 8; i++)
					reg_words[i] = '0;
			end
			2: begin
				// Upper bits beyond the 12-bit coordinate registers must be dropped.
				for (int i = 0; i < 8; i++)
					reg_words[i] = '1;
			end
			default: begin
				reg_words[REG_MOVE_CANCEL] = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom)
					: CFG_W'($urandom_range(0, 40));
				reg_words[REG_LONG_PRESS]  = CFG_W'($urandom_range(0, 1500));
				// The empty zone puts the left edge above the right edge.
				lo = int'($urandom_range((mode == 4) ? 1 : 0, 4095));
				hi = lo + int'($urandom_range(0, 1500));
				if (hi > 4095)
					hi = 4095;
				reg_words[REG_CORNER_LEFT]  = CFG_W'((mode == 4) ? hi : lo);
				reg_words[REG_CORNER_RIGHT] = CFG_W'((mode == 4) ? lo - 1 : hi);
				lo = int'($urandom_range(0, 4095));
				hi = lo + int'($urandom_range(0, 1500));
				if (hi > 4095)
					hi = 4095;
				reg_words[REG_CORNER_TOP]    = CFG_W'(lo);
				reg_words[REG_CORNER_BOTTOM] = CFG_W'(hi);
				reg_words[REG_CORNER_HOLD]   = CFG_W'($urandom_range(0, 3000));
				reg_words[REG_TAP_DEBOUNCE]  = CFG_W'($urandom_range(0, 800));
			end
		endcase
	endtask

	// One contact: a press, a run of held samples with jitter or jumps, then a release.
	task automatic press_gesture();
		int      n;
		int      m;
		int      px;
		int      py;
		int      span;
		sample_t s;
		span = int'(cfg.long_press_ms);
		if (int'(cfg.corner_hold_ms) > span)
			span = int'(cfg.corner_hold_ms);
		if (int'(cfg.tap_debounce_ms) > span)
			span = int'(cfg.tap_debounce_ms);
		span = span / 3 + 2;
		if ($urandom_range(0, 1) == 0 && cfg.corner_left <= cfg.corner_right
				&& cfg.corner_top <= cfg.corner_bottom) begin
			px = int'($urandom_range(cfg.corner_left, cfg.corner_right));
			py = int'($urandom_range(cfg.corner_top, cfg.corner_bottom));
		end else begin
			px = int'($urandom_range(0, 4095));
			py = int'($urandom_range(0, 4095));
		end
		clock_ms += TIME_W'($urandom_range(0, 2 * span));
		n = int'($urandom_range(1, 10));
		m = int'(cfg.move_cancel_px) + 1;
		for (int i = 0; i < n; i++) begin
			s.touched = 1'b1;
			s.pos_x   = COORD_W'(px);
			s.pos_y   = COORD_W'(py);
			s.now_ms  = clock_ms;
			send_sample(s, 1'b0, '0);
			if ($urandom_range(0, 9) < 8) begin
				px = px + int'($urandom_range(0, 2 * m)) - m;
				py = py + int'($urandom_range(0, 2 * m)) - m;
				px = (px < 0) ? 0 : (px > 4095) ? 4095 : px;
				py = (py < 0) ? 0 : (py > 4095) ? 4095 : py;
			end else begin
				px = int'($urandom_range(0, 4095));
				py = int'($urandom_range(0, 4095));
			end
			clock_ms += TIME_W'($urandom_range(0, span));
		end
		// Coordinates of a release sample are ignored by the block.
		s.touched = 1'b0;
		s.pos_x   = COORD_W'($urandom);
		s.pos_y   = COORD_W'($urandom);
		s.now_ms  = clock_ms;
		send_sample(s, 1'b0, '0);
	endtask

	task automatic add_row(input logic t, input int x, input int y, input logic [TIME_W-1:0] ms,
			input bit typed, input event_kind_t k, input int ex, input int ey);
		stim_row_t r;
		r.touched = t;
		r.x       = COORD_W'(x);
		r.y       = COORD_W'(y);
		r.ms      = ms;
		r.typed   = typed;
		r.kind    = k;
		r.ex      = COORD_W'(ex);
		r.ey      = COORD_W'(ey);
		script.push_back(r);
	endtask

	// Result checker, receiver stall and watchdog.
	always @(posedge clk) begin : result_watch
		result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_events.size() == 0) begin
					flag_mismatch($sformatf("unexpected event kind %0d", event_kind));
				end else begin
					want = pending_events.pop_front();
					if (event_kind !== want.kind || event_x !== want.x || event_y !== want.y
							|| pressed_now !== want.pressed_now)
						flag_mismatch($sformatf("got kind %0d (%0d,%0d) p%0b, want %0d (%0d,%0d) p%0b",
							event_kind, event_x, event_y, pressed_now,
							want.kind, want.x, want.y, want.pressed_now));
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Stimulus sequence.
	initial begin : stimulus
		sample_t s;
		result_t want;
		int      target;
		send_idle_pct = 0;
		stall_pct     = 0;
		items_sent    = 0;
		mismatches    = 0;
		quiet_cycles  = 0;
		clock_ms      = '0;
		gs            = '0;
		cfg           = '0;
		cfg.move_cancel_px  = MOVE_CANCEL_RST;
		cfg.long_press_ms   = LONG_PRESS_RST;
		cfg.corner_hold_ms  = CORNER_HOLD_RST;
		cfg.tap_debounce_ms = TAP_DEBOUNCE_RST;

		// Directed samples with reset configuration (corner zone is the single point 0,0).
		//      touch x     y     now_ms        typed kind        ex    ey
		add_row(0,    4095, 4095, 32'd0,        1,    EV_NONE,    0,    0);
		add_row(1,    100,  200,  32'd10,       1,    EV_NONE,    0,    0);
		add_row(0,    0,    0,    32'd50,       1,    EV_RELEASE, 100,  200);
		add_row(1,    4095, 4095, 32'd1000,     1,    EV_NONE,    0,    0);
		add_row(0,    0,    0,    32'd1100,     1,    EV_TAP,     4095, 4095);
		add_row(1,    0,    0,    32'd1150,     0,    EV_NONE,    0,    0);
		add_row(1,    0,    0,    32'd1950,     0,    EV_NONE,    0,    0);
		add_row(1,    0,    0,    32'd3150,     0,    EV_NONE,    0,    0);
		add_row(0,    9,    9,    32'd3200,     0,    EV_NONE,    0,    0);
		// Long press and corner press from the same sample.
		add_row(1,    0,    0,    32'd4000,     0,    EV_NONE,    0,    0);
		add_row(1,    0,    0,    32'd6000,     0,    EV_NONE,    0,    0);
		add_row(1,    0,    0,    32'd7000,     0,    EV_NONE,    0,    0);
		add_row(0,    0,    0,    32'd7010,     0,    EV_NONE,    0,    0);
		// Drift just past the limit, then exactly at it.
		add_row(1,    2000, 2000, 32'd8000,     0,    EV_NONE,    0,    0);
		add_row(1,    2021, 2000, 32'd8700,     0,    EV_NONE,    0,    0);
		add_row(1,    2041, 2020, 32'd9400,     0,    EV_NONE,    0,    0);
		add_row(1,    2041, 2020, 32'd9500,     0,    EV_NONE,    0,    0);
		add_row(0,    0,    0,    32'd9600,     0,    EV_NONE,    0,    0);
		// Two quick taps: the second falls inside the debounce window.
		add_row(1,    5,    7,    32'd9650,     0,    EV_NONE,    0,    0);
		add_row(0,    0,    0,    32'd9700,     0,    EV_NONE,    0,    0);
		add_row(1,    6,    8,    32'd9710,     0,    EV_NONE,    0,    0);
		add_row(0,    0,    0,    32'd9750,     0,    EV_NONE,    0,    0);
		// Hold across the timestamp wrap.
		add_row(1,    300,  300,  32'hFFFF_FF00, 1,   EV_NONE,    0,    0);
		add_row(1,    300,  300,  32'h0000_0300, 1,   EV_LONG,    300,  300);
		add_row(0,    0,    0,    32'h0000_0310, 1,   EV_RELEASE, 300,  300);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			s.touched         = script[i].touched;
			s.pos_x           = script[i].x;
			s.pos_y           = script[i].y;
			s.now_ms          = script[i].ms;
			want.kind         = script[i].kind;
			want.x            = script[i].ex;
			want.y            = script[i].ey;
			want.pressed_now  = script[i].touched;
			send_sample(s, script[i].typed, want);
		end
		clock_ms = 32'h0000_0400;

		// Random phases; each loads a register setting and picks an idling pattern.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			drain();
			case (p)
				0: pick_config(3);
				1: pick_config(1);
				2: pick_config(2);
				3: pick_config(3);
				4: pick_config(4);
				default: pick_config(0);
			endcase
			load_config();
			case (p % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 81; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 81; end
				default: begin send_idle_pct = 12; stall_pct = 12; end
			endcase
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) begin
				if ($urandom_range(0, 99) < 85) begin
					press_gesture();
				end else begin
					s.touched = 1'($urandom_range(0, 1));
					s.pos_x   = COORD_W'($urandom);
					s.pos_y   = COORD_W'($urandom);
					s.now_ms  = $urandom;
					send_sample(s, 1'b0, '0);
				end
				if ($urandom_range(0, 99) == 0)
					drain();
			end
		end

		// Let the last events come out, then a short settle.
		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_events.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
